### rtl/core/top_k_class_hit_checker_top_assert.svh
// Assertion macros used by the checker top module.
`ifndef TOP_K_CLASS_HIT_CHECKER_TOP_ASSERT_SVH
`define TOP_K_CLASS_HIT_CHECKER_TOP_ASSERT_SVH

// Property checked on every rising clock edge outside of reset.
`define TKC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define TKC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/tkc_pkg.sv
`timescale 1ns / 1ps

package tkc_pkg;

  // Fixed field widths of the interface.
  localparam int TRUE_CLASS_W = 10;
  localparam int TOP_K_W      = 4;

  localparam logic [TOP_K_W-1:0] TOP_K_RESET = 4'd1;

  // Flags one list cell hands to its lower-ranked neighbor.
  typedef struct packed {
    logic beat;   // the incoming pair ranks at or above this cell's pair
    logic valid;  // this cell holds a pair
  } link_t;

endpackage

### rtl/core/tkc_cell.sv
`timescale 1ns / 1ps

module tkc_cell #(
  parameter int SCORE_WIDTH = 32,
  parameter int CLASS_W     = 10,
  parameter int CMP_W       = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic                          clear,
  input  logic signed [SCORE_WIDTH-1:0] new_key,
  input  logic        [CLASS_W-1:0]     new_class,
  input  tkc_pkg::link_t                prev_link,
  input  logic signed [SCORE_WIDTH-1:0] prev_key,
  input  logic        [CLASS_W-1:0]     prev_class,
  input  logic        [CMP_W-1:0]       target,
  output tkc_pkg::link_t                link,
  output logic signed [SCORE_WIDTH-1:0] key,
  output logic        [CLASS_W-1:0]     cls,
  output logic                          match
);

  logic                          valid;
  logic                          take_prev;
  logic                          take_new;
  logic                          valid_next;
  logic signed [SCORE_WIDTH-1:0] key_next;
  logic        [CLASS_W-1:0]     cls_next;
  logic                          valid_upd;
  logic        [CLASS_W-1:0]     cls_upd;

  // The new class index is larger than any stored one, so an equal score
  // lets the new pair rank above the stored pair.
  assign link.beat  = !valid || (key <= new_key);
  assign link.valid = valid;

  // The list is sorted, so the cells the new pair beats form a tail. The
  // first of them takes the new pair, the rest shift down by one place.
  assign take_prev = link.beat && prev_link.beat;
  assign take_new  = link.beat && !prev_link.beat;

  always_comb begin
    valid_next = valid;
    key_next   = key;
    cls_next   = cls;
    if (take_prev) begin
      valid_next = prev_link.valid;
      key_next   = prev_key;
      cls_next   = prev_class;
    end else if (take_new) begin
      valid_next = 1'b1;
      key_next   = new_key;
      cls_next   = new_class;
    end
  end

  // Contents after the current request, used for the hit check.
  assign valid_upd = load ? valid_next : valid;
  assign cls_upd   = load ? cls_next : cls;
  assign match     = valid_upd && (CMP_W'(cls_upd) == target);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (clear) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key <= key_next;
      cls <= cls_next;
    end
  end

endmodule

### rtl/core/top_k_class_hit_checker_top.sv
`timescale 1ns / 1ps

// Top-k class hit checker. The class scores of one sample arrive one
// request per cycle, in class order, as signed Q16.16 values; the request
// that carries row_end also carries true_class and closes the sample. A row
// of MAX_K compare-and-shift cells keeps the best (score, class) pairs sorted,
// the higher score first and, on equal scores, the higher class index first.
// One request per cycle is accepted, with no gaps between samples. The
// result (hit) is presented in the cycle after the closing request and sits in
// an output register; item_ready drops only while that register holds a
// result that has not been taken. hit is 1 when true_class is among the first
// top_k entries; a top_k above MAX_K counts all entries, zero counts none,
// and a short row counts every class it holds. Scores at class index
// MAX_CLASSES and beyond are dropped, but their row_end still closes the row.
// The top_k register is written through the cfg channel and resets to 1; it
// must only be written while no sample is in flight.

module top_k_class_hit_checker_top #(
  parameter int MAX_K       = 8,
  parameter int MAX_CLASSES = 1024,
  parameter int SCORE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  logic signed [SCORE_WIDTH-1:0]        score,
  input  logic [tkc_pkg::TRUE_CLASS_W-1:0]     true_class,
  input  logic                                 row_end,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic                                 hit,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tkc_pkg::TOP_K_W-1:0]          cfg_top_k
);

  `include "top_k_class_hit_checker_top_assert.svh"

  localparam int CLASS_W = $clog2(MAX_CLASSES);
  localparam int CNT_W   = $clog2(MAX_CLASSES + 1);
  localparam int CMP_W   = (CLASS_W > tkc_pkg::TRUE_CLASS_W) ? CLASS_W
                                                             : tkc_pkg::TRUE_CLASS_W;

  logic [tkc_pkg::TOP_K_W-1:0] top_k;
  logic [CNT_W-1:0]            count;
  logic                        item_fire;
  logic                        load;
  logic                        row_done;
  logic [CMP_W-1:0]            target;

  tkc_pkg::link_t                link_vec  [MAX_K+1];
  logic signed [SCORE_WIDTH-1:0] key_vec   [MAX_K+1];
  logic        [CLASS_W-1:0]     cls_vec   [MAX_K+1];
  logic        [MAX_K-1:0]       match_vec;
  logic        [MAX_K-1:0]       in_k;
  logic        [MAX_K-1:0]       valid_vec;
  logic                          hit_next;

  assign cfg_ready  = 1'b1;
  assign item_ready = !result_valid || result_ready;
  assign item_fire  = item_valid && item_ready;
  assign row_done   = item_fire && row_end;
  // Scores beyond the last class index never enter the list.
  assign load       = item_fire && (count < CNT_W'(MAX_CLASSES));
  assign target     = CMP_W'(true_class);

  always_ff @(posedge clk) begin
    if (rst) begin
      top_k <= tkc_pkg::TOP_K_RESET;
    end else if (cfg_valid && cfg_ready) begin
      top_k <= cfg_top_k;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (row_done) begin
      count <= '0;
    end else if (load) begin
      count <= count + CNT_W'(1);
    end
  end

  // The head cell sees a neighbor that never yields its place.
  assign link_vec[0] = '{beat: 1'b0, valid: 1'b0};
  assign key_vec[0]  = '0;
  assign cls_vec[0]  = '0;

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    tkc_cell #(
      .SCORE_WIDTH (SCORE_WIDTH),
      .CLASS_W     (CLASS_W),
      .CMP_W       (CMP_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .load       (load),
      .clear      (row_done),
      .new_key    (score),
      .new_class  (count[CLASS_W-1:0]),
      .prev_link  (link_vec[i]),
      .prev_key   (key_vec[i]),
      .prev_class (cls_vec[i]),
      .target     (target),
      .link       (link_vec[i+1]),
      .key        (key_vec[i+1]),
      .cls        (cls_vec[i+1]),
      .match      (match_vec[i])
    );

    // Only the first top_k places count; a larger top_k counts them all.
    assign in_k[i]      = (32'(top_k) > i);
    assign valid_vec[i] = link_vec[i+1].valid;
  end

  assign hit_next = |(match_vec & in_k);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (row_done) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (row_done) begin
      hit <= hit_next;
    end
  end

  // Occupied cells always form an unbroken run from the head of the list;
  // before the first reset edge the cells hold no defined value.
  `TKC_ASSERT_ALWAYS(a_valid_run, rst || ((valid_vec & (valid_vec + MAX_K'(1))) == '0), "list has a gap")
  // A closed row leaves an empty list for the next sample.
  `TKC_ASSERT(a_row_clear, row_done |=> valid_vec == '0, "list not cleared after row end")
  // Every closed row produces a result on the next cycle.
  `TKC_ASSERT(a_row_result, row_done |=> result_valid, "no result after row end")
  // The class counter advances by one per stored score.
  `TKC_ASSERT(a_count_step, load && !row_end |=> count == $past(count) + CNT_W'(1), "class counter slip")

endmodule
